>>> rtl/lsd_pkg.sv
// Shared types and constants for the LIFO stack with search-and-remove.
`default_nettype none

package lsd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  // Operation codes of a request. Code 3 has no meaning and acts as a no-op.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_DOWN   = 2'd1,
    CELL_UP     = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_mode_t;

  // Control broadcast from the sequencer to the whole chain.
  typedef struct packed {
    cell_mode_t mode;
    word_t      wrap_data;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lsd_cell.sv
// One storage cell of the stack chain; cell 0 holds the top of the stack.
`default_nettype none

module lsd_cell
  import lsd_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      is_last,
  input  wire word_t     up_data,
  input  wire word_t     down_data,
  output word_t          data
);

  word_t data_next;

  // A push moves every entry one cell deeper; a pop or removal pulls the
  // deeper neighbor up. While rotating, the deepest occupied cell takes the
  // old top so the ring closes.
  always_comb begin
    unique case (ctl.mode)
      CELL_HOLD:   data_next = data;
      CELL_DOWN:   data_next = up_data;
      CELL_UP:     data_next = down_data;
      CELL_ROTATE: data_next = is_last ? ctl.wrap_data : down_data;
      default:     data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

>>> rtl/lifo_stack_with_search_delete.sv
// Top level of the LIFO stack with search-and-remove, built as a chain of cells.
`default_nettype none

// Usage
// A request is taken at a rising edge where start is high and busy is low;
// operation selects push, pop or search-and-remove, value is the word to
// push or to look for. Every request gives exactly one result: done is high
// for one cycle with status, result_value and entry_count, which is the
// entry count after the request. The receiver cannot stall, so results
// are never held back.
// Push, pop and the unused code leave busy low: the result shows in the
// cycle after the request, so one such request can be taken every cycle.
// A search on a non-empty stack rotates the chain through cell 0, one entry
// per cycle with busy high, dropping the first match it meets; its result
// shows in the same cycle that busy falls. A search on an empty stack
// answers like a pop and leaves busy low.
// Synchronous reset empties the stack and clears any pending result; the
// cell contents are not cleared, since only occupied cells are ever read.
module lifo_stack_with_search_delete
  import lsd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [31:0]      result_value,
  output logic [COUNT_W-1:0]      entry_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] steps, steps_next;
  logic      found, found_next;
  word_t     key, key_next;

  logic      accept;
  logic      hit;
  cell_ctl_t ctl;
  word_t     cell_data [DEPTH];
  logic      is_last [DEPTH];

  logic      res_load;
  status_t   res_status;
  word_t     res_value;

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  // The search only ever looks at cell 0: the chain turns under it.
  assign hit = !found && (cell_data[0] == key);

  always_comb begin
    state_next    = state;
    count_next    = count;
    steps_next    = steps;
    found_next    = found;
    key_next      = key;
    ctl.mode      = CELL_HOLD;
    ctl.wrap_data = cell_data[0];
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_value     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (op_t'(operation))
            OP_PUSH: begin
              if (count == CW'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ctl.mode   = CELL_DOWN;
                count_next = count + 1'b1;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.mode   = CELL_UP;
                count_next = count - 1'b1;
                res_value  = cell_data[0];
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else begin
                // The result comes at the end of the scan instead.
                res_load   = 1'b0;
                state_next = S_SCAN;
                steps_next = count;
                found_next = 1'b0;
                key_next   = value;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Either drop the matching top entry or rotate it to the bottom.
        // After as many steps as there were entries, the order is restored.
        if (hit) begin
          ctl.mode   = CELL_UP;
          count_next = count - 1'b1;
          found_next = 1'b1;
        end else begin
          ctl.mode = CELL_ROTATE;
        end
        steps_next = steps - 1'b1;
        if (steps == CW'(1)) begin
          state_next = S_IDLE;
          res_load   = 1'b1;
          if (found || hit) begin
            res_status = ST_OK;
            res_value  = key;
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      steps <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      steps <= steps_next;
      found <= found_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (res_load) begin
      status       <= res_status;
      result_value <= res_value;
      entry_count  <= COUNT_W'(count_next);
    end
  end

  // The cell chain. Cell 0 takes the pushed value from above; the deepest
  // cell has no lower neighbor and reloads itself on a pull.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    word_t up_d, down_d;

    assign is_last[k] = (CW'(k + 1) == count);

    if (k == 0) begin : g_top
      assign up_d = value;
    end else begin : g_mid
      assign up_d = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_bottom
      assign down_d = cell_data[k];
    end else begin : g_inner
      assign down_d = cell_data[k+1];
    end

    lsd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .is_last   (is_last[k]),
      .up_data   (up_d),
      .down_data (down_d),
      .data      (cell_data[k])
    );
  end

  // No result is shown while a scan is running.
  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during a scan");

  // A push onto a full stack reports full and leaves the count alone.
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PUSH && count == CW'(DEPTH))
      |=> (done && status == ST_FULL && $stable(count)))
    else $error("push on full stack mishandled");

  // A pop from a non-empty stack takes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_POP && count != '0)
      |=> (done && count == $past(count) - 1'b1))
    else $error("pop did not remove one entry");

  // The last scan step always produces a result.
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && steps == CW'(1)) |=> (done && !busy))
    else $error("scan ended without a result");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register lost its one-hot code");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the LIFO stack with search-and-remove.
`timescale 1ns / 1ps

module tb_top
  import lsd_pkg::*;
();

  localparam int unsigned DEPTH = 16;
  // Operation code 3 has no meaning in the block and must act as a no-op.
  localparam logic [1:0] OP_NOP = 2'd3;
  // Consecutive cycles with neither a request nor a result taken before the run is
  // declared hung. The longest legal quiet stretch is a long sender gap plus a
  // full-depth search, well under this.
  localparam int unsigned HANG_LIMIT = 500;
  localparam int unsigned MAX_PRINTED = 30;
  localparam int unsigned RANDOM_ITEMS = 1230;

  // What one request is expected to produce.
  typedef struct {
    status_t              status;
    word_t                data;
    logic [COUNT_W-1:0]   count;
  } stack_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         operation = OP_PUSH;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] result_value;
  logic [COUNT_W-1:0] entry_count;

  // Our own copy of the stack contents, updated as each request is taken.
  word_t        stack_model [DEPTH];
  int unsigned  stack_fill = 0;
  stack_reply_t replies_due [$];

  // Values that pushes and searches mostly draw from, so that searches hit
  // often and duplicates exercise the nearest-to-top rule.
  word_t value_pool [8];
  bit    gaps_on = 1'b1;

  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned ops_taken [4];
  int unsigned status_seen [4];
  int unsigned quiet_cycles = 0;

  lifo_stack_with_search_delete #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .done        (done),
    .status      (status),
    .result_value(result_value),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every failure goes through here. Only the first few are printed so that
  // a broken build does not flood the log, but all of them are counted.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Applies one request to the stack copy and returns the result it must give.
  // A search walks from the top down, so the match nearest the top is removed,
  // and the entries above it each drop one place to close the gap.
  function automatic stack_reply_t predict_reply(input logic [1:0] op, input word_t data);
    stack_reply_t r;
    int           hit;
    r.status = ST_OK;
    r.data   = '0;
    hit      = -1;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_model[stack_fill] = data;
          stack_fill++;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.data = stack_model[stack_fill];
        end
      end
      OP_SEARCH: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = int'(stack_fill) - 1; i >= 0 && hit < 0; i--) begin
            if (stack_model[i] == data) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int i = hit; i + 1 < int'(stack_fill); i++) begin
              stack_model[i] = stack_model[i + 1];
            end
            stack_fill--;
            r.data = data;
          end
        end
      end
      default: ;
    endcase
    r.count = stack_fill[COUNT_W-1:0];
    ops_taken[op]++;
    status_seen[r.status]++;
    return r;
  endfunction

  // Result checking and prediction share one block, with the check first, so
  // a result is always matched against requests taken at earlier edges. All
  // signals are read at the rising edge, before any update of that edge lands.
  always @(posedge clk) begin : result_check
    stack_reply_t due;
    if (!rst) begin
      if (done) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status) begin
            report_mismatch($sformatf("status %0d, expected %s", status, due.status.name()));
          end
          if (result_value !== due.data) begin
            report_mismatch($sformatf("result_value %0d, expected %0d", result_value,
                                      due.data));
          end
          if (entry_count !== due.count) begin
            report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count,
                                      due.count));
          end
        end
      end
      if (start && !busy) begin
        replies_due.push_back(predict_reply(operation, value));
        requests_taken++;
      end
    end
  end

  // Hang detection: the counter restarts whenever a request or a result is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("Watchdog: no request or result taken for %0d cycles", HANG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one request and holds it until the block takes it. The start
  // line is left high on return so that a back-to-back request does not
  // lower and raise it within the same time step.
  task automatic send_request(input logic [1:0] op, input word_t data);
    start     <= 1'b1;
    operation <= op;
    value     <= data;
    do @(posedge clk); while (busy);
  endtask

  // Random idle time between requests: mostly none or a few cycles, rarely long.
  task automatic idle_between_requests();
    int unsigned roll;
    int unsigned gap;
    if (!gaps_on) return;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every request taken so far has answered.
  task automatic wait_until_answered();
    start <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return value_pool[$urandom_range(0, 7)];
    if (roll < 84) return 32'sh8000_0000;
    if (roll < 88) return 32'sh7fff_ffff;
    return word_t'($urandom);
  endfunction

  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct,
                             input int unsigned search_pct);
    int unsigned roll;
    logic [1:0]  op;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) op = OP_PUSH;
    else if (roll < push_pct + pop_pct) op = OP_POP;
    else if (roll < push_pct + pop_pct + search_pct) op = OP_SEARCH;
    else op = OP_NOP;
    send_request(op, pick_value());
    idle_between_requests();
  endtask

  // Pop, search and no-op on a freshly reset, empty stack.
  task automatic test_empty_stack();
    send_request(OP_POP, 32'sd0);
    send_request(OP_SEARCH, 32'sd0);
    send_request(OP_NOP, -32'sd1);
  endtask

  // Extreme values, a miss, a top match, a bottom match that closes the gap,
  // and a drain down to an empty pop.
  task automatic test_field_extremes();
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PUSH, 32'sh7fff_ffff);
    send_request(OP_PUSH, 32'sd0);
    send_request(OP_PUSH, -32'sd1);
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_SEARCH, 32'sh5a5a_5a5a);
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_POP, 32'sh7fff_ffff);
    send_request(OP_SEARCH, 32'sh7fff_ffff);
    send_request(OP_NOP, -32'sd1);
    send_request(OP_POP, 32'sd0);
    send_request(OP_POP, -32'sd1);
  endtask

  // Fills the stack to the top, pushes into a full stack, then removes
  // entries deep inside it and refills. The stack copy is read only after
  // every result has come, when it no longer changes.
  task automatic test_full_stack();
    word_t bottom;
    word_t middle;
    wait_until_answered();
    repeat (DEPTH - stack_fill) begin
      send_request(OP_PUSH, $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)]
                                                 : word_t'($urandom));
      idle_between_requests();
    end
    send_request(OP_PUSH, pick_value());
    wait_until_answered();
    bottom = stack_model[0];
    middle = stack_model[DEPTH / 2];
    send_request(OP_SEARCH, bottom);
    send_request(OP_SEARCH, middle);
    send_request(OP_PUSH, pick_value());
    send_request(OP_PUSH, pick_value());
    send_request(OP_PUSH, pick_value());
  endtask

  // Alternating fill-heavy and drain-heavy phases of random length, so the
  // stack keeps sweeping between empty and full. Some phases run without
  // gaps, and every few phases the sender waits for all results.
  task automatic test_random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_no;
    sent     = 0;
    phase_no = 0;
    while (sent < items) begin
      phase_len = $urandom_range(30, 70);
      gaps_on   = ($urandom_range(0, 3) != 0);
      value_pool[$urandom_range(0, 7)] = word_t'($urandom);
      repeat (phase_len) begin
        if (phase_no % 2 == 0) send_random(72, 12, 13);
        else send_random(20, 40, 37);
        sent++;
      end
      phase_no++;
      if (phase_no % 4 == 0) wait_until_answered();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    // A small pool of mostly small numbers with two full-width entries.
    for (int i = 0; i < 6; i++) value_pool[i] = word_t'($urandom_range(0, 15));
    value_pool[6] = word_t'($urandom);
    value_pool[7] = -32'sd1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_field_extremes();
    test_full_stack();
    test_random_traffic(RANDOM_ITEMS);

    // Let every result come back, then allow one full search time for a
    // stray result before closing.
    wait_until_answered();
    repeat (DEPTH + 4) @(posedge clk);
    if (replies_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
    end

    $display("Covered %0d requests: %0d push, %0d pop, %0d search, %0d no-op.",
             requests_taken, ops_taken[OP_PUSH], ops_taken[OP_POP], ops_taken[OP_SEARCH],
             ops_taken[OP_NOP]);
    $display("Outcomes: %0d ok, %0d empty, %0d not found, %0d full.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
